// File: src/dtfp_pkg.sv
// shared types, constants and float helpers for the decimal text parser
// no dependencies; imported by the interfaces and all modules
package dtfp_pkg;

  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  localparam logic [31:0] SAFE_INT_LIMIT = 32'd429496719;
  localparam logic [34:0] EXP_LIMIT      = 35'd2147483647;

  localparam logic [31:0] FLT_INF  = 32'h7F80_0000;
  localparam logic [31:0] FLT_QNAN = 32'h7FC0_0000;
  localparam logic [31:0] FLT_TEN  = 32'h4120_0000;

  localparam int POW_NEG_MAX = 50;
  localparam int POW_POS_MAX = 38;
  localparam int POW_N       = POW_NEG_MAX + POW_POS_MAX + 1;
  localparam int POW_IW      = $clog2(POW_N);

  localparam logic [31:0] DIGIT_FLT [10] = '{
    32'h0000_0000, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h4080_0000,
    32'h40A0_0000, 32'h40C0_0000, 32'h40E0_0000, 32'h4100_0000, 32'h4110_0000
  };

  // float unit operations
  localparam logic [1:0] FOP_I2F = 2'd0;
  localparam logic [1:0] FOP_MUL = 2'd1;
  localparam logic [1:0] FOP_ADD = 2'd2;

  // float micro-operations issued by the controller
  localparam logic [2:0] UOP_I2F   = 3'd0;
  localparam logic [2:0] UOP_MUL10 = 3'd1;
  localparam logic [2:0] UOP_ADDD  = 3'd2;
  localparam logic [2:0] UOP_MULSC = 3'd3;
  localparam logic [2:0] UOP_ADDIP = 3'd4;
  localparam logic [2:0] UOP_MULPW = 3'd5;

  typedef struct packed {
    logic       load_char;
    logic       count;
    logic       set_mneg;
    logic       int_step;
    logic       frac_inc;
    logic       exp_sign;
    logic       exp_digit;
    logic       fp_issue;
    logic       fp_write;
    logic [2:0] uop;
    logic       copy_ipart;
    logic       clear_acc;
    logic       load_out;
    logic       out_sel;
    logic       clear_all;
  } dtfp_cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_dot;
    logic is_e;
    logic is_minus;
    logic is_plus;
    logic fmode;
    logic int_small;
    logic facc_inf;
    logic exp_ovf;
  } dtfp_sts_t;

  // round m * 2^x (m nonzero) to nearest single, ties to even
  function automatic logic [31:0] pack_float(input logic [63:0] m, input int x);
    int          p;
    int          e;
    int          sh;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] bits;
    p    = 0;
    q    = '0;
    rem  = '0;
    half = '0;
    for (int k = 0; k < 64; k++) begin
      if (m[k]) p = k;
    end
    e = p + x;
    if (e > 127) begin
      bits = FLT_INF;
    end else begin
      if (e < -126) e = -126;
      sh = e - 23 - x;
      if (sh <= 0) begin
        q = m << (-sh);
      end else if (sh > 64) begin
        q = '0;
      end else begin
        rem  = (sh == 64) ? m : (m & ((64'd1 << sh) - 64'd1));
        half = 64'd1 << (sh - 1);
        q    = (sh == 64) ? 64'd0 : (m >> sh);
        if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      end
      bits = (32'(e + 126) << 23) + q[31:0];
      if (bits >= FLT_INF) bits = FLT_INF;
    end
    return bits;
  endfunction

  // correctly rounded single of 10^mag or 10^-mag, evaluated at elaboration
  function automatic logic [31:0] pow10_bits(input logic neg, input int mag);
    logic [127:0] d;
    logic [127:0] r;
    logic [63:0]  m;
    logic [63:0]  q;
    int           s;
    int           n;
    int           got;
    logic         bv;
    logic [31:0]  res;
    d   = 128'd1;
    r   = 128'd1;
    m   = '0;
    q   = '0;
    s   = 0;
    n   = 0;
    got = 0;
    bv  = 1'b0;
    res = '0;
    if (!neg && mag > POW_POS_MAX) begin
      res = FLT_INF;
    end else if (neg && mag > POW_NEG_MAX) begin
      res = '0;
    end else begin
      for (int i = 0; i < POW_NEG_MAX; i++) begin
        if (i < mag) d = d * 128'd5;
      end
      if (!neg) begin
        for (int k = 0; k < 64; k++) begin
          if (s == k && (d[127:64] >> k) != 64'd0) s = k + 1;
        end
        if (s == 0) begin
          m = d[63:0];
        end else begin
          m = 64'(d >> s);
          if ((d[63:0] & ((64'd1 << s) - 64'd1)) != 64'd0) m[0] = 1'b1;
        end
        res = pack_float(m, s + mag);
      end else begin
        for (int k = 0; k < 256; k++) begin
          if (got < 64) begin
            r  = r << 1;
            n  = n + 1;
            bv = (r >= d);
            if (bv) r = r - d;
            if (got > 0 || bv) begin
              q   = {q[62:0], bv};
              got = got + 1;
            end
          end
        end
        if (r != 128'd0) q[0] = 1'b1;
        res = pack_float(q, -n - mag);
      end
    end
    return res;
  endfunction

endpackage

// File: src/dtfp_if.sv
// request channels of the decimal text parser: character in, parsed value out
// depends on dtfp_pkg
interface dtfp_in_if import dtfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_char;

  modport source (output valid, output text_char, input ready);
  modport sink   (input valid, input text_char, output ready);
endinterface

interface dtfp_out_if import dtfp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value_bits;
  logic [COUNT_W-1:0] consumed_count;
  logic [CHAR_W-1:0]  stop_char;

  modport source (output valid, output value_bits, output consumed_count,
                  output stop_char, input ready);
  modport sink   (input valid, input value_bits, input consumed_count,
                  input stop_char, output ready);
endinterface

// File: src/decimal_text_to_float_parser.sv
// top level of the decimal text to single-precision parser
// depends on dtfp_pkg, dtfp_if, dtfp_fpu, dtfp_dpath and dtfp_ctrl
//
//   channel  dir  payload                                      request moves
//   in_i     in   text_char[7:0]                               one character
//   out_o    out  value_bits[31:0] consumed_count[6:0] stop_char[7:0]  one number
//
// a character that only updates integer, exponent or counter state is just decoded;
// one needing float ops runs them in turn on the shared two-stage unit, then finishes;
// at most three ops (float digit with conversion: convert, times ten, add digit)
// reset clears the parse state and the output valid; no clearing pass
// a finished number waits in the output register while the next characters are taken;
// only a second finished number stalls until the first request is taken
module decimal_text_to_float_parser import dtfp_pkg::*; #(
  parameter int MAX_LEN         = 64,
  parameter int FRAC_TABLE_SIZE = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dtfp_in_if.sink       in_i,
  dtfp_out_if.source    out_o
);

  dtfp_cmd_t cmd;
  dtfp_sts_t sts;

  dtfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dtfp_dpath #(
    .MAX_LEN         (MAX_LEN),
    .FRAC_TABLE_SIZE (FRAC_TABLE_SIZE)
  ) u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .char_i  (in_i.text_char),
    .sts_o   (sts),
    .value_o (out_o.value_bits),
    .count_o (out_o.consumed_count),
    .stop_o  (out_o.stop_char)
  );

endmodule

// File: src/dtfp_fpu.sv
// two-stage single-precision unit for non-negative operands: mul, add, u32 to float
// stage one forms the exact product or aligned sum, stage two rounds; uses dtfp_pkg
module dtfp_fpu import dtfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        issue_i,
  input  logic [1:0]  op_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] res_o
);

  localparam int M_W = 51;

  localparam logic [1:0] SP_NONE = 2'd0;
  localparam logic [1:0] SP_INF  = 2'd1;
  localparam logic [1:0] SP_NAN  = 2'd2;

  logic [7:0]  ea, eb, eab, ebb;
  logic [22:0] fa, fb;
  logic [23:0] ma, mb;
  logic        a_inf, b_inf, a_nan, b_nan, a_zero, b_zero;
  logic signed [9:0] eua, eub;

  logic        a_big;
  logic [23:0] mbg, msm;
  logic signed [9:0] eubg;
  logic [7:0]  dd;
  logic [5:0]  dd_c;
  logic [63:0] wide, shifted;
  logic        lost;

  logic [M_W-1:0]    m_d, m_q;
  logic signed [9:0] x_d, x_q;
  logic [1:0]        sp_d, sp_q;

  always_comb begin
    ea     = a_i[30:23];
    eb     = b_i[30:23];
    fa     = a_i[22:0];
    fb     = b_i[22:0];
    eab    = (ea == 8'd0) ? 8'd1 : ea;
    ebb    = (eb == 8'd0) ? 8'd1 : eb;
    ma     = {ea != 8'd0, fa};
    mb     = {eb != 8'd0, fb};
    a_inf  = (ea == 8'hFF) && (fa == 23'd0);
    b_inf  = (eb == 8'hFF) && (fb == 23'd0);
    a_nan  = (ea == 8'hFF) && (fa != 23'd0);
    b_nan  = (eb == 8'hFF) && (fb != 23'd0);
    a_zero = (ea == 8'd0) && (fa == 23'd0);
    b_zero = (eb == 8'd0) && (fb == 23'd0);
    eua    = $signed({2'b00, eab}) - 10'sd127;
    eub    = $signed({2'b00, ebb}) - 10'sd127;

    // alignment for the adder, larger exponent kept whole
    a_big   = (eab >= ebb);
    mbg     = a_big ? ma : mb;
    msm     = a_big ? mb : ma;
    eubg    = a_big ? eua : eub;
    dd      = a_big ? (eab - ebb) : (ebb - eab);
    dd_c    = (dd > 8'd63) ? 6'd63 : dd[5:0];
    wide    = 64'({msm, 26'd0});
    shifted = wide >> dd_c;
    lost    = ((shifted << dd_c) != wide);

    m_d  = '0;
    x_d  = '0;
    sp_d = SP_NONE;
    case (op_i)
      FOP_MUL: begin
        m_d = M_W'(ma * mb);
        x_d = eua + eub - 10'sd46;
        if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
          sp_d = SP_NAN;
        end else if (a_inf || b_inf) begin
          sp_d = SP_INF;
        end
      end
      FOP_ADD: begin
        m_d = M_W'({mbg, 26'd0}) + (M_W'(shifted[M_W-1:0]) | M_W'(lost));
        x_d = eubg - 10'sd49;
        if (a_nan || b_nan) begin
          sp_d = SP_NAN;
        end else if (a_inf || b_inf) begin
          sp_d = SP_INF;
        end
      end
      FOP_I2F: begin
        m_d = M_W'(a_i);
        x_d = '0;
      end
      default: begin
        m_d  = '0;
        sp_d = SP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= SP_NONE;
    end else if (issue_i) begin
      sp_q <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      m_q <= m_d;
      x_q <= x_d;
    end
  end

  always_comb begin
    case (sp_q)
      SP_NAN:  res_o = FLT_QNAN;
      SP_INF:  res_o = FLT_INF;
      default: res_o = (m_q == '0) ? 32'd0 : pack_float(64'(m_q), int'(x_q));
    endcase
  end

endmodule

// File: src/dtfp_dpath.sv
// datapath of the parser: accumulators, exponent, counters, tables and the float unit
// driven by dtfp_ctrl commands; uses dtfp_pkg and dtfp_fpu
module dtfp_dpath import dtfp_pkg::*; #(
  parameter int MAX_LEN         = 64,
  parameter int FRAC_TABLE_SIZE = 17
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dtfp_cmd_t          cmd_i,
  input  logic [CHAR_W-1:0]  char_i,
  output dtfp_sts_t          sts_o,
  output logic [VALUE_W-1:0] value_o,
  output logic [COUNT_W-1:0] count_o,
  output logic [CHAR_W-1:0]  stop_o
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int FCW   = $clog2(FRAC_TABLE_SIZE);

  logic [31:0] frac_tab [FRAC_TABLE_SIZE];
  logic [31:0] pow_tab  [POW_N];

  for (genvar g = 0; g < FRAC_TABLE_SIZE; g++) begin : g_frac
    localparam logic [31:0] FV = (g == 0) ? 32'd0 : pow10_bits(1'b1, g);
    assign frac_tab[g] = FV;
  end

  for (genvar g = 0; g < POW_N; g++) begin : g_pow
    localparam logic [31:0] PV = (g < POW_NEG_MAX) ? pow10_bits(1'b1, POW_NEG_MAX - g)
                                                   : pow10_bits(1'b0, g - POW_NEG_MAX);
    assign pow_tab[g] = PV;
  end

  logic [CHAR_W-1:0] char_q;
  logic [31:0]       int_q, facc_q, ipart_q;
  logic              fmode_q, mneg_q, eneg_q;
  logic [FCW-1:0]    fcnt_q;
  logic [30:0]       emag_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [VALUE_W-1:0] out_val_q;
  logic [COUNT_W-1:0] out_cnt_q;
  logic [CHAR_W-1:0]  out_chr_q;

  logic [3:0]        dig;
  logic [34:0]       exp_t;
  logic [POW_IW-1:0] pidx;
  logic [31:0]       pow_val;
  logic [1:0]        fop;
  logic [31:0]       fa, fb, fres;
  logic [31:0]       osrc, obits;

  assign dig   = char_q[3:0];
  assign exp_t = ({4'd0, emag_q} << 3) + ({4'd0, emag_q} << 1) + 35'(dig);

  always_comb begin
    sts_o.is_digit  = (char_q >= "0") && (char_q <= "9");
    sts_o.is_dot    = (char_q == ".");
    sts_o.is_e      = (char_q == "e") || (char_q == "E");
    sts_o.is_minus  = (char_q == "-");
    sts_o.is_plus   = (char_q == "+");
    sts_o.fmode     = fmode_q;
    sts_o.int_small = (int_q < SAFE_INT_LIMIT);
    sts_o.facc_inf  = (facc_q == FLT_INF);
    sts_o.exp_ovf   = (exp_t > EXP_LIMIT);
  end

  always_comb begin
    pidx = eneg_q ? (POW_IW'(POW_NEG_MAX) - POW_IW'(emag_q[5:0]))
                  : (POW_IW'(POW_NEG_MAX) + POW_IW'(emag_q[5:0]));
    if (!eneg_q && emag_q > 31'(POW_POS_MAX)) begin
      pow_val = FLT_INF;
    end else if (eneg_q && emag_q > 31'(POW_NEG_MAX)) begin
      pow_val = 32'd0;
    end else begin
      pow_val = pow_tab[pidx];
    end
  end

  always_comb begin
    case (cmd_i.uop)
      UOP_I2F:   begin fop = FOP_I2F; fa = int_q;   fb = 32'd0;            end
      UOP_MUL10: begin fop = FOP_MUL; fa = facc_q;  fb = FLT_TEN;          end
      UOP_ADDD:  begin fop = FOP_ADD; fa = facc_q;  fb = DIGIT_FLT[dig];   end
      UOP_MULSC: begin fop = FOP_MUL; fa = facc_q;  fb = frac_tab[fcnt_q]; end
      UOP_ADDIP: begin fop = FOP_ADD; fa = ipart_q; fb = facc_q;           end
      UOP_MULPW: begin fop = FOP_MUL; fa = ipart_q; fb = pow_val;          end
      default:   begin fop = FOP_I2F; fa = 32'd0;   fb = 32'd0;            end
    endcase
  end

  dtfp_fpu u_fpu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (cmd_i.fp_issue),
    .op_i    (fop),
    .a_i     (fa),
    .b_i     (fb),
    .res_o   (fres)
  );

  // sign applied last, any nan folded to the quiet pattern
  always_comb begin
    osrc  = cmd_i.out_sel ? ipart_q : facc_q;
    obits = osrc ^ {mneg_q, 31'd0};
    if (obits[30:23] == 8'hFF && obits[22:0] != 23'd0) obits = FLT_QNAN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q   <= '0;
      facc_q  <= '0;
      fmode_q <= 1'b0;
      ipart_q <= '0;
      fcnt_q  <= '0;
      eneg_q  <= 1'b0;
      emag_q  <= '0;
      cnt_q   <= '0;
      mneg_q  <= 1'b0;
    end else if (cmd_i.clear_all) begin
      int_q   <= '0;
      facc_q  <= '0;
      fmode_q <= 1'b0;
      ipart_q <= '0;
      fcnt_q  <= '0;
      eneg_q  <= 1'b0;
      emag_q  <= '0;
      cnt_q   <= '0;
      mneg_q  <= 1'b0;
    end else begin
      if (cmd_i.count && cnt_q < CNT_W'(MAX_LEN)) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.set_mneg) mneg_q <= 1'b1;
      if (cmd_i.int_step) int_q <= (int_q << 3) + (int_q << 1) + 32'(dig);
      if (cmd_i.frac_inc && fcnt_q < FCW'(FRAC_TABLE_SIZE - 1)) fcnt_q <= fcnt_q + 1'b1;
      if (cmd_i.exp_sign) eneg_q <= sts_o.is_minus;
      if (cmd_i.exp_digit) emag_q <= sts_o.exp_ovf ? EXP_LIMIT[30:0] : exp_t[30:0];
      if (cmd_i.fp_write) begin
        case (cmd_i.uop)
          UOP_I2F: begin
            facc_q  <= fres;
            fmode_q <= 1'b1;
          end
          UOP_ADDIP, UOP_MULPW: ipart_q <= fres;
          default: facc_q <= fres;
        endcase
      end
      if (cmd_i.copy_ipart) ipart_q <= facc_q;
      if (cmd_i.clear_acc) begin
        int_q   <= '0;
        facc_q  <= '0;
        fmode_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_char) char_q <= char_i;
    if (cmd_i.load_out) begin
      out_val_q <= obits;
      out_cnt_q <= COUNT_W'(cnt_q);
      out_chr_q <= char_q;
    end
  end

  assign value_o = out_val_q;
  assign count_o = out_cnt_q;
  assign stop_o  = out_chr_q;

endmodule

// File: src/dtfp_ctrl.sv
// controller of the parser: parse phase, decode of each character, float op sequencing
// commands dtfp_dpath through dtfp_cmd_t; uses dtfp_pkg
module dtfp_ctrl import dtfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  dtfp_sts_t sts_i,
  output dtfp_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_FP   = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam logic [2:0] PH_START     = 3'd0;
  localparam logic [2:0] PH_INT       = 3'd1;
  localparam logic [2:0] PH_INT_DONE  = 3'd2;
  localparam logic [2:0] PH_FRAC      = 3'd3;
  localparam logic [2:0] PH_FRAC_DONE = 3'd4;
  localparam logic [2:0] PH_EXP_SIGN  = 3'd5;
  localparam logic [2:0] PH_EXP_DIG   = 3'd6;
  localparam logic [2:0] PH_EXP_DONE  = 3'd7;

  localparam logic [2:0] P_NONE     = 3'd0;
  localparam logic [2:0] P_DIGIT    = 3'd1;
  localparam logic [2:0] P_IPART    = 3'd2;
  localparam logic [2:0] P_EMIT_ACC = 3'd3;
  localparam logic [2:0] P_FRAC_IP  = 3'd4;
  localparam logic [2:0] P_EMIT_FR  = 3'd5;
  localparam logic [2:0] P_EMIT_EXP = 3'd6;

  logic [1:0] state_q, state_d;
  logic [2:0] phase_q, phase_d;
  logic [2:0] plan_q, plan_d;
  logic [2:0] uop_q, uop_d;
  logic       wt_q, wt_d;
  logic       ov_q, ov_d;
  logic [2:0] ph;
  logic [2:0] pl;
  logic       emit;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;

  always_comb begin
    cmd_o    = '0;
    cmd_o.uop = uop_q;
    state_d  = state_q;
    phase_d  = phase_q;
    plan_d   = plan_q;
    uop_d    = uop_q;
    wt_d     = wt_q;
    ph       = (phase_q == PH_START) ? PH_INT : phase_q;
    pl       = P_NONE;
    emit     = (plan_q == P_EMIT_ACC) || (plan_q == P_EMIT_FR) || (plan_q == P_EMIT_EXP);

    case (state_q)
      S_IDLE: begin
        cmd_o.load_char = in_valid_i;
        if (in_valid_i) state_d = S_DEC;
      end

      S_DEC: begin
        phase_d = ph;
        if (phase_q == PH_START && sts_i.is_minus) begin
          cmd_o.count    = 1'b1;
          cmd_o.set_mneg = 1'b1;
        end else begin
          case (ph)
            PH_INT, PH_INT_DONE: begin
              if (ph == PH_INT && sts_i.is_digit) begin
                cmd_o.count = 1'b1;
                if (!sts_i.fmode && sts_i.int_small) cmd_o.int_step = 1'b1;
                else pl = P_DIGIT;
              end else if (sts_i.is_dot || sts_i.is_e) begin
                cmd_o.count = 1'b1;
                phase_d     = sts_i.is_dot ? PH_FRAC : PH_EXP_SIGN;
                pl          = P_IPART;
              end else begin
                pl = P_EMIT_ACC;
              end
            end
            PH_FRAC, PH_FRAC_DONE: begin
              if (ph == PH_FRAC && sts_i.is_digit) begin
                cmd_o.count    = 1'b1;
                cmd_o.frac_inc = 1'b1;
                if (!sts_i.fmode && sts_i.int_small) cmd_o.int_step = 1'b1;
                else pl = P_DIGIT;
              end else if (sts_i.is_e) begin
                cmd_o.count = 1'b1;
                phase_d     = PH_EXP_SIGN;
                pl          = P_FRAC_IP;
              end else begin
                pl = P_EMIT_FR;
              end
            end
            PH_EXP_SIGN, PH_EXP_DIG: begin
              if (ph == PH_EXP_SIGN && (sts_i.is_minus || sts_i.is_plus)) begin
                cmd_o.count    = 1'b1;
                cmd_o.exp_sign = 1'b1;
                phase_d        = PH_EXP_DIG;
              end else if (sts_i.is_digit) begin
                cmd_o.count     = 1'b1;
                cmd_o.exp_digit = 1'b1;
                phase_d         = sts_i.exp_ovf ? PH_EXP_DONE : PH_EXP_DIG;
              end else begin
                pl = P_EMIT_EXP;
              end
            end
            default: pl = P_EMIT_EXP;
          endcase
        end
        plan_d = pl;
        wt_d   = 1'b0;
        if (pl == P_NONE) begin
          state_d = S_IDLE;
        end else if (pl == P_EMIT_EXP) begin
          uop_d   = UOP_MULPW;
          state_d = S_FP;
        end else if (!sts_i.fmode) begin
          uop_d   = UOP_I2F;
          state_d = S_FP;
        end else if (pl == P_DIGIT) begin
          uop_d   = UOP_MUL10;
          state_d = S_FP;
        end else if (pl == P_FRAC_IP || pl == P_EMIT_FR) begin
          uop_d   = UOP_MULSC;
          state_d = S_FP;
        end else begin
          state_d = S_FIN;
        end
      end

      S_FP: begin
        if (!wt_q) begin
          cmd_o.fp_issue = 1'b1;
          wt_d           = 1'b1;
        end else begin
          cmd_o.fp_write = 1'b1;
          wt_d           = 1'b0;
          state_d        = S_FIN;
          case (uop_q)
            UOP_I2F: begin
              if (plan_q == P_DIGIT) begin
                uop_d   = UOP_MUL10;
                state_d = S_FP;
              end else if (plan_q == P_FRAC_IP || plan_q == P_EMIT_FR) begin
                uop_d   = UOP_MULSC;
                state_d = S_FP;
              end
            end
            UOP_MUL10: begin
              uop_d   = UOP_ADDD;
              state_d = S_FP;
            end
            UOP_MULSC: begin
              uop_d   = UOP_ADDIP;
              state_d = S_FP;
            end
            default: state_d = S_FIN;
          endcase
        end
      end

      S_FIN: begin
        if (emit) begin
          // wait for the output register to drain
          if (!ov_q || out_ready_i) begin
            cmd_o.load_out  = 1'b1;
            cmd_o.out_sel   = (plan_q != P_EMIT_ACC);
            cmd_o.clear_all = 1'b1;
            phase_d         = PH_START;
            state_d         = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
          if (plan_q == P_DIGIT && sts_i.facc_inf) begin
            phase_d = (phase_q == PH_FRAC) ? PH_FRAC_DONE : PH_INT_DONE;
          end
          if (plan_q == P_IPART) begin
            cmd_o.copy_ipart = 1'b1;
            cmd_o.clear_acc  = 1'b1;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase

    ov_d = (ov_q && !out_ready_i) || cmd_o.load_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_START;
      plan_q  <= P_NONE;
      uop_q   <= UOP_I2F;
      wt_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      plan_q  <= plan_d;
      uop_q   <= uop_d;
      wt_q    <= wt_d;
      ov_q    <= ov_d;
    end
  end

  a_write_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fp_write |-> $past(cmd_o.fp_issue))
    else $error("float write without a preceding issue");

  a_idle_no_float: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd_o.fp_issue && !cmd_o.fp_write)
    else $error("float unit busy while taking a character");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!ov_q || out_ready_i))
    else $error("pending result overwritten");

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DEC))
    else $error("accepted character not decoded");

endmodule
